// ===== src/nlp_pkg.sv =====
// Shared constants, codes and word types for the next-permutation stepper.
package nlp_pkg;

  // Element store geometry
  localparam int MAX_SIZE = 14;
  localparam int MIN_SIZE = 2;
  localparam int ELEM_W   = 4;
  localparam int PERM_W   = MAX_SIZE * ELEM_W;
  localparam int IDX_W    = $clog2(MAX_SIZE);
  localparam int CNT_W    = $clog2(MAX_SIZE + 1);

  // Configuration register
  localparam int SIZE_W = 4;
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(4);

  // Register port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [APB_AW-3:0] REG_SIZE_IN_USE = '0;

  typedef enum logic [1:0] {
    CMD_RESTART = 2'd0,
    CMD_LOAD    = 2'd1,
    CMD_ADVANCE = 2'd2,
    CMD_HOLD    = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_PIV_START,
    ST_PIV_PRIME,
    ST_PIV_SCAN,
    ST_SUC_START,
    ST_SUC_SCAN,
    ST_SWAP_P,
    ST_SWAP_J,
    ST_REV_RD,
    ST_REV_W1,
    ST_REV_W2,
    ST_RESULT
  } state_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [PERM_W-1:0] perm_in;
  } in_word_t;

  typedef struct packed {
    logic [PERM_W-1:0] perm_out;
    logic              advanced;
  } out_word_t;

  // Requests from the port logic to the stepping engine
  typedef struct packed {
    logic              start;
    cmd_t              cmd;
    logic [PERM_W-1:0] perm;
    logic              refill;
    logic              res_ready;
  } eng_req_t;

  // Status from the stepping engine
  typedef struct packed {
    logic idle;
    logic done;
    logic advanced;
  } eng_stat_t;

endpackage

// ===== src/nlp_engine.sv =====
// Element memory, packed shadow and the sequencer that steps the permutation.
module nlp_engine (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [nlp_pkg::CNT_W-1:0]    n,
  input  nlp_pkg::eng_req_t            req,
  output nlp_pkg::eng_stat_t           stat,
  output logic [nlp_pkg::PERM_W-1:0]   perm
);
  import nlp_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_SIZE - 1);
  localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);

  state_t state, state_next;

  // Element store and its registered read ports
  logic [ELEM_W-1:0] mem [MAX_SIZE];
  logic [ELEM_W-1:0] rd_a, rd_b;
  logic [PERM_W-1:0] shadow;

  // Control registers
  logic [IDX_W-1:0] pos;
  logic             fill_load;
  logic             fill_report;
  logic             adv;

  // Working registers
  logic [IDX_W-1:0]  p, l, r;
  logic [ELEM_W-1:0] prev, piv, succ;
  logic [PERM_W-1:0] ld;

  // Memory port controls
  logic              we, ra_en, rb_en;
  logic [IDX_W-1:0]  wa, ra, rb;
  logic [ELEM_W-1:0] wd;

  // Shared compare unit and index arithmetic
  logic [IDX_W-1:0]  nm1, pos_dn;
  logic              ascent, bigger, rev_go, rev_more, in_range;
  logic [ELEM_W-1:0] fill_val;

  assign nm1      = IDX_W'(n - CNT_W'(1));
  assign pos_dn   = pos - IDX_ONE;
  assign ascent   = rd_a < prev;
  assign bigger   = (rd_a > piv) || (pos == p + IDX_ONE);
  assign rev_go   = (p + IDX_ONE) < nm1;
  assign rev_more = (l + IDX_ONE) < (r - IDX_ONE);
  assign in_range = CNT_W'(pos) < n;
  assign fill_val = in_range ? (fill_load ? ld[ELEM_W-1:0] : ELEM_W'(pos)) : '0;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req.start) begin
          case (req.cmd)
            CMD_RESTART, CMD_LOAD: state_next = ST_FILL;
            CMD_ADVANCE:           state_next = ST_PIV_START;
            default:               state_next = ST_RESULT;
          endcase
        end
      end
      ST_FILL: begin
        if (pos == LAST_IDX) state_next = fill_report ? ST_RESULT : ST_IDLE;
      end
      ST_PIV_START: state_next = ST_PIV_PRIME;
      ST_PIV_PRIME: state_next = ST_PIV_SCAN;
      ST_PIV_SCAN: begin
        if (ascent)           state_next = ST_SUC_START;
        else if (pos == '0)   state_next = ST_RESULT;
      end
      ST_SUC_START: state_next = ST_SUC_SCAN;
      ST_SUC_SCAN: begin
        if (bigger) state_next = ST_SWAP_P;
      end
      ST_SWAP_P: state_next = ST_SWAP_J;
      ST_SWAP_J: state_next = rev_go ? ST_REV_RD : ST_RESULT;
      ST_REV_RD: state_next = ST_REV_W1;
      ST_REV_W1: state_next = ST_REV_W2;
      ST_REV_W2: state_next = rev_more ? ST_REV_W1 : ST_RESULT;
      ST_RESULT: begin
        if (req.res_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
    if (req.refill) state_next = ST_FILL;
  end

  // Memory port controls per state
  always_comb begin
    we    = 1'b0;
    wa    = '0;
    wd    = '0;
    ra_en = 1'b0;
    ra    = '0;
    rb_en = 1'b0;
    rb    = '0;
    case (state)
      ST_FILL: begin
        we = 1'b1;
        wa = pos;
        wd = fill_val;
      end
      ST_PIV_START: begin
        ra_en = 1'b1;
        ra    = nm1;
      end
      ST_PIV_PRIME: begin
        ra_en = 1'b1;
        ra    = nm1 - IDX_ONE;
      end
      ST_PIV_SCAN: begin
        if (!ascent && pos != '0) begin
          ra_en = 1'b1;
          ra    = pos_dn;
        end
      end
      ST_SUC_START: begin
        ra_en = 1'b1;
        ra    = nm1;
      end
      ST_SUC_SCAN: begin
        if (!bigger) begin
          ra_en = 1'b1;
          ra    = pos_dn;
        end
      end
      ST_SWAP_P: begin
        we = 1'b1;
        wa = p;
        wd = succ;
      end
      ST_SWAP_J: begin
        we = 1'b1;
        wa = pos;
        wd = piv;
      end
      ST_REV_RD: begin
        ra_en = 1'b1;
        ra    = l;
        rb_en = 1'b1;
        rb    = r;
      end
      ST_REV_W1: begin
        we = 1'b1;
        wa = l;
        wd = rd_b;
      end
      ST_REV_W2: begin
        we = 1'b1;
        wa = r;
        wd = rd_a;
        if (rev_more) begin
          ra_en = 1'b1;
          ra    = l + IDX_ONE;
          rb_en = 1'b1;
          rb    = r - IDX_ONE;
        end
      end
      default: ;
    endcase
  end

  // Element store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (ra_en) rd_a <= mem[ra];
    if (rb_en) rd_b <= mem[rb];
  end

  // Mirror every write into the packed word for the result
  always_ff @(posedge clk) begin
    if (we) shadow[wa*ELEM_W +: ELEM_W] <= wd;
  end

  // Sequencer control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_FILL;
      pos         <= '0;
      fill_load   <= 1'b0;
      fill_report <= 1'b0;
      adv         <= 1'b0;
    end else begin
      state <= state_next;
      // Restart the identity sweep on a size change
      if (req.refill) begin
        pos         <= '0;
        fill_load   <= 1'b0;
        fill_report <= 1'b0;
      end else begin
        case (state)
          ST_IDLE: begin
            if (req.start) begin
              pos         <= '0;
              adv         <= 1'b0;
              fill_load   <= (req.cmd == CMD_LOAD);
              fill_report <= 1'b1;
            end
          end
          ST_FILL:      pos <= pos + IDX_ONE;
          ST_PIV_PRIME: pos <= nm1 - IDX_ONE;
          ST_PIV_SCAN: begin
            if (!ascent) pos <= pos_dn;
          end
          ST_SUC_START: pos <= nm1;
          ST_SUC_SCAN: begin
            if (!bigger) pos <= pos_dn;
          end
          ST_SWAP_J:    adv <= 1'b1;
          default: ;
        endcase
      end
    end
  end

  // Working values of the step
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req.start) ld <= req.perm;
      end
      ST_FILL:      ld   <= ld >> ELEM_W;
      ST_PIV_PRIME: prev <= rd_a;
      ST_PIV_SCAN: begin
        if (ascent) begin
          p   <= pos;
          piv <= rd_a;
        end else begin
          prev <= rd_a;
        end
      end
      ST_SUC_SCAN: begin
        if (bigger) succ <= rd_a;
      end
      ST_SWAP_J: begin
        l <= p + IDX_ONE;
        r <= nm1;
      end
      ST_REV_W2: begin
        l <= l + IDX_ONE;
        r <= r - IDX_ONE;
      end
      default: ;
    endcase
  end

  // Status towards the port logic
  always_comb begin
    stat.idle     = (state == ST_IDLE);
    stat.done     = (state == ST_RESULT);
    stat.advanced = adv;
  end

  assign perm = shadow;

endmodule

// ===== src/next_lexicographic_permutation.sv =====
// Next lexicographic permutation stepper: top level with handshake and register port.
// Holds a permutation of n = size_in_use (clamped to 2..14) nibbles and, per input
// word, restarts it at the identity, loads it from perm_in, or advances it to the
// next arrangement in lexicographic order; every input word gives one output word
// with the packed permutation and the advanced flag (0 when already the last one).
// The elements live in a small memory with two registered read ports and one
// write port, walked by a single compare unit under a sequencer, one position a
// cycle. Restart and load sweep all 14 entries with writes and then give their
// output word from the result state. Advance primes the reads, scans down for the
// pivot, restarts the read, scans down for the successor, makes two writes for the
// swap, and, where the suffix needs it, reads and then writes each pair of the
// suffix reversal before the result state; with no pivot it goes straight to the
// result. An unused command goes straight to the result state. The next word is
// accepted at the earliest in the cycle after the result is taken.
// in_stall is high while a word is in work and after reset and after each write of
// size_in_use, while the store is swept to the identity. A finished word waits in
// the output register without blocking the next input word.
module next_lexicographic_permutation (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  nlp_pkg::in_word_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output nlp_pkg::out_word_t            out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [nlp_pkg::APB_AW-1:0]    paddr,
  input  logic [nlp_pkg::APB_DW-1:0]    pwdata,
  output logic [nlp_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);
  import nlp_pkg::*;

  logic [SIZE_W-1:0] size_in_use;
  logic [CNT_W-1:0]  n;
  logic              reg_hit, cfg_wr;
  eng_req_t          req;
  eng_stat_t         stat;
  logic [PERM_W-1:0] perm;

  // Register port: single register, no wait states
  assign pready  = 1'b1;
  assign reg_hit = (paddr[APB_AW-1:2] == REG_SIZE_IN_USE);
  assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
  assign prdata  = reg_hit ? APB_DW'(size_in_use) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use <= SIZE_RESET;
    end else if (cfg_wr) begin
      size_in_use <= pwdata[SIZE_W-1:0];
    end
  end

  // Clamp the active size to the supported range
  always_comb begin
    if (int'(size_in_use) < MIN_SIZE) begin
      n = CNT_W'(MIN_SIZE);
    end else if (int'(size_in_use) > MAX_SIZE) begin
      n = CNT_W'(MAX_SIZE);
    end else begin
      n = CNT_W'(size_in_use);
    end
  end

  // Accept a word only while the engine is idle
  assign in_stall = !stat.idle;

  always_comb begin
    req.start     = in_valid && !in_stall;
    req.cmd       = in_data.cmd;
    req.perm      = in_data.perm_in;
    req.refill    = cfg_wr;
    req.res_ready = !out_valid || !out_stall;
  end

  nlp_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .n    (n),
    .req  (req),
    .stat (stat),
    .perm (perm)
  );

  // Output register: load a finished word, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stat.done && req.res_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done && req.res_ready) begin
      out_data.perm_out <= perm;
      out_data.advanced <= stat.advanced;
    end
  end

endmodule

// ===== src/nlp_checker.sv =====
// Port-level checks for the permutation stepper, bound to the top level.
module nlp_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input nlp_pkg::out_word_t  out_data
);
  import nlp_pkg::*;

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  // One word at a time: the input stalls right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accepting a word");

  // The identity sweep after reset blocks the input
  a_sweep_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> in_stall)
    else $error("input accepted during the reset sweep");

  // A new output word only comes out of work in progress
  a_no_spurious_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("output word without work in progress");

endmodule

bind next_lexicographic_permutation nlp_checker u_nlp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the next lexicographic permutation stepper.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import nlp_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int RST_CYCLES  = 11;
  localparam int MAX_WAIT    = 6;
  localparam int SETTLE      = 60;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_WORDS = 50;
  localparam int DIR_ROWS    = 26;
  localparam logic [APB_AW-1:0] SIZE_ADDR = {REG_SIZE_IN_USE, 2'b00};

  // One row of the directed table: optional size write, then one input word
  typedef struct packed {
    logic              cfg;
    logic [SIZE_W-1:0] cfg_val;
    in_word_t          w;
    logic              typed;
    logic [PERM_W-1:0] exp_perm;
    logic              exp_adv;
  } dir_row_t;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{1'b0, 4'd0,  '{CMD_HOLD,    56'hA5_A5A5_A5A5_A5A5}, 1'b1, 56'h3210, 1'b0},
    '{1'b0, 4'd0,  '{CMD_ADVANCE, 56'h0},                 1'b1, 56'h2310, 1'b1},
    '{1'b0, 4'd0,  '{CMD_LOAD,    56'hFF_FFFF_FFFF_0123}, 1'b1, 56'h0123, 1'b0},
    '{1'b0, 4'd0,  '{CMD_ADVANCE, 56'hFF_FFFF_FFFF_FFFF}, 1'b1, 56'h0123, 1'b0},
    '{1'b0, 4'd0,  '{CMD_RESTART, 56'hFF_FFFF_FFFF_FFFF}, 1'b1, 56'h3210, 1'b0},
    '{1'b0, 4'd0,  '{CMD_LOAD,    56'hFF_FFFF_FFFF_FFFF}, 1'b1, 56'hFFFF, 1'b0},
    '{1'b0, 4'd0,  '{CMD_ADVANCE, 56'h0},                 1'b1, 56'hFFFF, 1'b0},
    '{1'b0, 4'd0,  '{CMD_LOAD,    56'h0},                 1'b1, 56'h0,    1'b0},
    '{1'b0, 4'd0,  '{CMD_LOAD,    56'h1001},              1'b0, 56'h0,    1'b0},
    '{1'b0, 4'd0,  '{CMD_ADVANCE, 56'h0},                 1'b0, 56'h0,    1'b0},
    '{1'b0, 4'd0,  '{CMD_ADVANCE, 56'h0},                 1'b0, 56'h0,    1'b0},
    '{1'b1, 4'd14, '{CMD_HOLD,    56'h0},    1'b1, 56'hDC_BA98_7654_3210, 1'b0},
    '{1'b0, 4'd0,  '{CMD_ADVANCE, 56'h0},    1'b1, 56'hCD_BA98_7654_3210, 1'b1},
    '{1'b0, 4'd0,  '{CMD_LOAD,    56'h01_2345_6789_ABCD}, 1'b1, 56'h01_2345_6789_ABCD, 1'b0},
    '{1'b0, 4'd0,  '{CMD_ADVANCE, 56'h0},    1'b1, 56'h01_2345_6789_ABCD, 1'b0},
    '{1'b0, 4'd0,  '{CMD_LOAD,    56'h01_2345_6789_ABDC}, 1'b0, 56'h0, 1'b0},
    '{1'b0, 4'd0,  '{CMD_ADVANCE, 56'h0},                 1'b0, 56'h0, 1'b0},
    '{1'b1, 4'd0,  '{CMD_HOLD,    56'hFF_FFFF_FFFF_FFFF}, 1'b1, 56'h10, 1'b0},
    '{1'b0, 4'd0,  '{CMD_ADVANCE, 56'h0},                 1'b1, 56'h01, 1'b1},
    '{1'b0, 4'd0,  '{CMD_ADVANCE, 56'h0},                 1'b1, 56'h01, 1'b0},
    '{1'b1, 4'd15, '{CMD_HOLD,    56'h0},    1'b1, 56'hDC_BA98_7654_3210, 1'b0},
    '{1'b0, 4'd0,  '{CMD_LOAD,    56'hFF_FFFF_FFFF_FFFE}, 1'b0, 56'h0, 1'b0},
    '{1'b0, 4'd0,  '{CMD_ADVANCE, 56'h0},                 1'b0, 56'h0, 1'b0},
    '{1'b1, 4'd1,  '{CMD_LOAD,    56'hFF_FFFF_FFFF_FFFE}, 1'b1, 56'hFE, 1'b0},
    '{1'b0, 4'd0,  '{CMD_ADVANCE, 56'h0},                 1'b1, 56'hEF, 1'b1},
    '{1'b1, 4'd3,  '{CMD_ADVANCE, 56'h0},                 1'b1, 56'h120, 1'b1}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  next_lexicographic_permutation uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predictor state: element store and size register
  logic [ELEM_W-1:0] arrangement [MAX_SIZE];
  logic [SIZE_W-1:0] size_reg;

  out_word_t pending_words [$];
  out_word_t head_word;
  int fails = 0;
  int words_checked = 0;
  int steps_taken = 0;
  int size_writes = 0;
  int cycles = 0;
  int rcv_hold = 0;
  logic idle_on = 1'b1;

  always #CLK_HALF clk = ~clk;

  // Clamp the size register to the usable range
  function automatic int active_len();
    int n;
    n = int'(size_reg);
    if (n < MIN_SIZE) n = MIN_SIZE;
    if (n > MAX_SIZE) n = MAX_SIZE;
    return n;
  endfunction

  function automatic void fill_identity();
    int n;
    n = active_len();
    for (int i = 0; i < MAX_SIZE; i++) arrangement[i] = (i < n) ? ELEM_W'(i) : '0;
  endfunction

  // Step to the next arrangement; returns 0 when already non-increasing
  function automatic logic advance_arrangement();
    int n, p, j, l, r;
    logic [ELEM_W-1:0] t;
    n = active_len();
    p = n - 1;
    while (p > 0 && arrangement[p-1] >= arrangement[p]) p--;
    if (p == 0) return 1'b0;
    p = p - 1;
    j = n - 1;
    while (j > p + 1 && arrangement[j] <= arrangement[p]) j--;
    t = arrangement[p];
    arrangement[p] = arrangement[j];
    arrangement[j] = t;
    l = p + 1;
    r = n - 1;
    while (l < r) begin
      t = arrangement[l];
      arrangement[l] = arrangement[r];
      arrangement[r] = t;
      l++;
      r--;
    end
    return 1'b1;
  endfunction

  // Apply one accepted word to the predictor and return the word it should give
  function automatic out_word_t predict_word(in_word_t w);
    out_word_t o;
    int n;
    n = active_len();
    o = '0;
    case (w.cmd)
      CMD_RESTART: fill_identity();
      CMD_LOAD: begin
        for (int i = 0; i < MAX_SIZE; i++)
          arrangement[i] = (i < n) ? w.perm_in[ELEM_W*i +: ELEM_W] : '0;
      end
      CMD_ADVANCE: o.advanced = advance_arrangement();
      default: ;
    endcase
    for (int i = 0; i < MAX_SIZE; i++) o.perm_out[ELEM_W*i +: ELEM_W] = arrangement[i];
    return o;
  endfunction

  // Offer one word after a drawn gap and log its expected result on acceptance
  task automatic send_word(in_word_t w, logic typed, out_word_t typed_out);
    int gap;
    out_word_t o;
    gap = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    o = predict_word(w);
    pending_words.push_back(typed ? typed_out : o);
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  // One register transfer: setup cycle, then access cycle until pready
  task automatic apb_xfer(logic wr, logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= wr;
    paddr <= SIZE_ADDR;
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_size_readback();
    logic [APB_DW-1:0] rd;
    apb_xfer(1'b0, '0, rd);
    if (rd[SIZE_W-1:0] !== size_reg) begin
      $error("size_in_use readback: expected %0d, actual %0d", size_reg, rd[SIZE_W-1:0]);
      fails++;
    end
  endtask

  // Let the block go idle, then change the size and confirm it reads back
  task automatic write_size(logic [SIZE_W-1:0] v);
    logic [APB_DW-1:0] rd;
    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    apb_xfer(1'b1, APB_DW'(v), rd);
    size_reg = v;
    fill_identity();
    size_writes++;
    check_size_readback();
  endtask

  // Random word: mostly advances over well-formed permutations, some multisets
  function automatic in_word_t make_word();
    in_word_t w;
    logic [63:0] r;
    logic [ELEM_W-1:0] el [MAX_SIZE];
    logic [ELEM_W-1:0] t;
    int n, k, s, pick;
    n = active_len();
    r = {$urandom(), $urandom()};
    w.perm_in = r[PERM_W-1:0];
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      w.cmd = CMD_ADVANCE;
    end else if (pick < 80) begin
      w.cmd = CMD_LOAD;
      for (int i = 0; i < MAX_SIZE; i++) el[i] = ELEM_W'(i);
      for (int i = n - 1; i > 0; i--) begin
        k = $urandom_range(0, i);
        t = el[i];
        el[i] = el[k];
        el[k] = t;
      end
      // sort a tail descending so the walk reaches the end of the order
      s = $urandom_range(0, n);
      for (int a = n - s; a < n; a++)
        for (int b = a + 1; b < n; b++)
          if (el[b] > el[a]) begin
            t = el[a];
            el[a] = el[b];
            el[b] = t;
          end
      for (int i = 0; i < n; i++) w.perm_in[ELEM_W*i +: ELEM_W] = el[i];
    end else if (pick < 92) begin
      w.cmd = CMD_LOAD;
      k = $urandom_range(1, 15);
      for (int i = 0; i < n; i++) w.perm_in[ELEM_W*i +: ELEM_W] = ELEM_W'($urandom_range(0, k));
    end else if (pick < 96) begin
      w.cmd = CMD_RESTART;
    end else begin
      w.cmd = CMD_HOLD;
    end
    return w;
  endfunction

  // Hold the offered result for a drawn number of cycles
  always @(negedge clk) begin
    if (out_valid && rcv_hold > 0) begin
      out_stall <= 1'b1;
      rcv_hold--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        $error("output word with nothing expected: perm_out %h", out_data.perm_out);
        fails++;
      end else begin
        head_word = pending_words.pop_front();
        words_checked++;
        if (head_word.advanced) steps_taken++;
        if (out_data.perm_out !== head_word.perm_out) begin
          $error("perm_out: expected %h, actual %h", head_word.perm_out, out_data.perm_out);
          fails++;
        end
        if (out_data.advanced !== head_word.advanced) begin
          $error("advanced: expected %0b, actual %0b", head_word.advanced, out_data.advanced);
          fails++;
        end
      end
      rcv_hold = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("next_lexicographic_permutation verification failed");
      $finish;
    end
  end

  initial begin
    out_word_t typed_out;
    in_word_t w;
    size_reg = SIZE_RESET;
    fill_identity();
    repeat (RST_CYCLES) @(negedge clk);
    rst <= 1'b0;
    check_size_readback();

    // Directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_rows[i].cfg) write_size(dir_rows[i].cfg_val);
      typed_out.perm_out = dir_rows[i].exp_perm;
      typed_out.advanced = dir_rows[i].exp_adv;
      send_word(dir_rows[i].w, dir_rows[i].typed, typed_out);
    end

    // Random phases, each at its own size; the sender drains before each write
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == 0) write_size(SIZE_W'(MAX_SIZE));
      else if (ph == 1) write_size(SIZE_W'(MIN_SIZE));
      else write_size(SIZE_W'($urandom_range(0, 15)));
      idle_on = (ph % 3 != 2);
      for (int k = 0; k < PHASE_WORDS; k++) begin
        w = make_word();
        send_word(w, 1'b0, typed_out);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    $display("checked %0d result words over %0d size writes, %0d of them real steps",
             words_checked, size_writes, steps_taken);
    if (fails == 0) begin
      $display("next_lexicographic_permutation verification clean");
    end else begin
      $display("next_lexicographic_permutation verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/nlp_pkg.sv
src/nlp_engine.sv
src/next_lexicographic_permutation.sv
src/nlp_checker.sv
tb/sv/tb_top.sv
